// ----- sv/gmp_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gmp_pkg
// Shared constants and types for the constrained minimum path sum block.
// ============================================================================
package gmp_pkg;

    // Default sizing of the block
    localparam int DEF_MAX_COLS  = 64;
    localparam int DEF_MAX_ROWS  = 1024;
    localparam int DEF_COST_BITS = 8;
    localparam int DEF_SUM_BITS  = 20;

    // Configuration register file
    localparam int NUM_COLS_W = 7;
    localparam int NUM_ROWS_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = NUM_COLS_W'(6);
    localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = NUM_ROWS_W'(6);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_COLS = 2'd0,
        REG_NUM_ROWS = 2'd1
    } cfg_reg_e;

    // Position of the cell in the compute stage within the grid
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_col;
    } cell_pos_t;

endpackage

// ----- sv/grid_min_path_no_repeat_dir.sv -----
`timescale 1ns / 1ps
// ============================================================================
// grid_min_path_no_repeat_dir
// Constrained minimum path sum over a cost grid streamed in row-major order.
// ============================================================================
// Cells are taken one per clock while no finishing cell is blocked: a cell
// passes an input register, then a single compute stage that reads the
// previous row's not-right sum of the column to the left, not-straight sum
// of its own column and not-left sum of the next column, and writes its own
// sums back into the row store. The row store is a single-port-read memory
// addressed two columns ahead of the compute stage, so its registered data
// arrive one column ahead. The result register is loaded as the last cell
// of the grid leaves the compute stage; the last cell waits in the input
// register only while an earlier result is still held on the result
// channel. A write to either grid-size register restarts the grid.
module grid_min_path_no_repeat_dir import gmp_pkg::*; #(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int COST_BITS = DEF_COST_BITS,
    parameter int SUM_BITS  = DEF_SUM_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // cell stream
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COST_BITS-1:0]  s_cell_cost,
    // result stream
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SUM_BITS-1:0]   m_min_cost,
    output logic                  m_no_path,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int ENT_W  = 3 * SUM_BITS;
    localparam logic [SUM_BITS-1:0] INF = {SUM_BITS{1'b1}};

    // configuration
    logic [NUM_COLS_W-1:0] num_cols_reg;
    logic [NUM_ROWS_W-1:0] num_rows_reg;
    logic                  cfg_hit;
    logic [CCNT_W-1:0]     cols_eff;
    logic [RCNT_W-1:0]     rows_eff;

    // input register
    logic                 in_vld_reg;
    logic [COST_BITS-1:0] in_cost_reg;

    // grid position and running best
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [SUM_BITS-1:0] best_reg;
    logic [SUM_BITS-1:0] best_next;

    // previous-row window
    logic [ENT_W-1:0]    cur_reg;    // old sums of the current column
    logic [SUM_BITS-1:0] lr_reg;     // old not-right sum of the column to the left
    logic [ENT_W-1:0]    ahead_data; // old sums of the next column in sequence

    // result register
    logic                m_valid_reg;
    logic [SUM_BITS-1:0] m_min_cost_reg;
    logic                m_no_path_reg;

    // step control
    logic [CCNT_W-1:0] col_plus;
    logic [CCNT_W-1:0] c1_plus;
    logic [RCNT_W-1:0] row_plus;
    logic [COL_W-1:0]  col_c1;
    logic [COL_W-1:0]  col_c2;
    logic              last_col;
    logic              last_row;
    logic              grid_end;
    logic              advance;
    logic              s_fire;
    cell_pos_t         pos;

    logic [ENT_W-1:0]    new_entry;
    logic [SUM_BITS-1:0] new_min;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && ((cfg_index == REG_NUM_COLS) ||
                                     (cfg_index == REG_NUM_ROWS));

    // Clamp the grid size to the supported range
    always_comb begin
        if (num_cols_reg == '0) begin
            cols_eff = CCNT_W'(1);
        end else if (32'(num_cols_reg) > 32'(MAX_COLS)) begin
            cols_eff = CCNT_W'(MAX_COLS);
        end else begin
            cols_eff = CCNT_W'(num_cols_reg);
        end
        if (num_rows_reg == '0) begin
            rows_eff = RCNT_W'(1);
        end else if (32'(num_rows_reg) > 32'(MAX_ROWS)) begin
            rows_eff = RCNT_W'(MAX_ROWS);
        end else begin
            rows_eff = RCNT_W'(num_rows_reg);
        end
    end

    // Column sequence: this one, the next and the one after (with wrap)
    always_comb begin
        col_plus = CCNT_W'(col_reg) + CCNT_W'(1);
        last_col = (col_plus >= cols_eff);
        col_c1   = last_col ? '0 : col_plus[COL_W-1:0];
        c1_plus  = CCNT_W'(col_c1) + CCNT_W'(1);
        col_c2   = (c1_plus >= cols_eff) ? '0 : c1_plus[COL_W-1:0];
        row_plus = RCNT_W'(row_reg) + RCNT_W'(1);
        last_row = (row_plus >= rows_eff);
        grid_end = last_col && last_row;
    end

    // Compute stage moves unless a finishing cell meets a blocked result slot
    assign advance = in_vld_reg && !(grid_end && m_valid_reg && !m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign pos.first_row = (row_reg == '0);
    assign pos.first_col = (col_reg == '0);
    assign pos.last_col  = last_col;

    gmp_cell #(
        .COST_BITS (COST_BITS),
        .SUM_BITS  (SUM_BITS)
    ) u_cell (
        .cost         (in_cost_reg),
        .pos          (pos),
        .cur_straight (cur_reg[2*SUM_BITS-1:SUM_BITS]),
        .left_right   (lr_reg),
        .right_left   (ahead_data[SUM_BITS-1:0]),
        .new_entry    (new_entry),
        .new_min      (new_min)
    );

    // Row store, read two columns ahead of the write
    gmp_row_mem #(
        .DEPTH (MAX_COLS),
        .WIDTH (ENT_W)
    ) u_row_mem (
        .aclk    (aclk),
        .wr_en   (advance),
        .wr_addr (col_reg),
        .wr_data (new_entry),
        .rd_en   (advance),
        .rd_addr (col_c2),
        .rd_data (ahead_data)
    );

    // Best over the bottom row
    always_comb begin
        best_next = best_reg;
        if (last_row && (new_min < best_reg)) begin
            best_next = new_min;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg <= NUM_COLS_RST;
            num_rows_reg <= NUM_ROWS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_NUM_COLS: num_cols_reg <= cfg_data[NUM_COLS_W-1:0];
                REG_NUM_ROWS: num_rows_reg <= cfg_data[NUM_ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_fire) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cost_reg <= s_cell_cost;
        end
    end

    // Grid position and running best
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            best_reg <= INF;
        end else if (cfg_hit) begin
            col_reg  <= '0;
            row_reg  <= '0;
            best_reg <= INF;
        end else if (advance) begin
            col_reg <= col_c1;
            if (last_col) begin
                row_reg <= last_row ? '0 : row_plus[ROW_W-1:0];
            end
            best_reg <= grid_end ? INF : best_next;
        end
    end

    // Previous-row window; a one-column grid feeds its own result back
    always_ff @(posedge aclk) begin
        if (advance) begin
            cur_reg <= (col_c1 == col_reg) ? new_entry : ahead_data;
            lr_reg  <= cur_reg[3*SUM_BITS-1:2*SUM_BITS];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && grid_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && grid_end) begin
            m_min_cost_reg <= best_next;
            m_no_path_reg  <= (best_next == INF);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_min_cost = m_min_cost_reg;
    assign m_no_path  = m_no_path_reg;

endmodule

// ----- sv/gmp_row_mem.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gmp_row_mem
// Previous-row store: one write and one read port, registered read data.
// A read of the address being written in the same cycle returns the new data.
// ============================================================================
module gmp_row_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 60,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, write-first on an address collision
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/gmp_cell.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gmp_cell
// Cell update: three saturating sums, one per excluded move, plus their min.
// ============================================================================
module gmp_cell import gmp_pkg::*; #(
    parameter int COST_BITS = DEF_COST_BITS,
    parameter int SUM_BITS  = DEF_SUM_BITS
) (
    input  logic [COST_BITS-1:0]  cost,
    input  cell_pos_t             pos,
    input  logic [SUM_BITS-1:0]   cur_straight,  // not-straight sum, same column
    input  logic [SUM_BITS-1:0]   left_right,    // not-right sum, column to the left
    input  logic [SUM_BITS-1:0]   right_left,    // not-left sum, column to the right
    output logic [3*SUM_BITS-1:0] new_entry,     // {not_right, not_straight, not_left}
    output logic [SUM_BITS-1:0]   new_min
);

    localparam int ADD_W = ((COST_BITS > SUM_BITS) ? COST_BITS : SUM_BITS) + 1;
    localparam logic [SUM_BITS-1:0] INF = {SUM_BITS{1'b1}};

    logic [SUM_BITS-1:0] l_right;
    logic [SUM_BITS-1:0] m_straight;
    logic [SUM_BITS-1:0] r_left;
    logic [SUM_BITS-1:0] n_left;
    logic [SUM_BITS-1:0] n_straight;
    logic [SUM_BITS-1:0] n_right;
    logic [SUM_BITS-1:0] min_ls;

    function automatic logic [SUM_BITS-1:0] min2(input logic [SUM_BITS-1:0] a,
                                                 input logic [SUM_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [SUM_BITS-1:0] sat_add(input logic [COST_BITS-1:0] c,
                                                    input logic [SUM_BITS-1:0]  s);
        logic [ADD_W-1:0] ce;
        logic [ADD_W-1:0] se;
        logic [ADD_W-1:0] inf_e;
        logic [ADD_W-1:0] sum;
        ce    = ADD_W'(c);
        se    = ADD_W'(s);
        inf_e = ADD_W'(INF);
        sum   = ce + se;
        if ((ce >= inf_e) || (se >= inf_e) || (sum >= inf_e)) begin
            return INF;
        end
        return sum[SUM_BITS-1:0];
    endfunction

    // Neighbours: row above the grid is zero, outside columns are infinity
    always_comb begin
        if (pos.first_row) begin
            l_right    = '0;
            m_straight = '0;
            r_left     = '0;
        end else begin
            l_right    = pos.first_col ? INF : left_right;
            m_straight = cur_straight;
            r_left     = pos.last_col ? INF : right_left;
        end
    end

    // Each sum excludes one arriving move
    assign n_left     = sat_add(cost, min2(m_straight, l_right));
    assign n_straight = sat_add(cost, min2(l_right, r_left));
    assign n_right    = sat_add(cost, min2(r_left, m_straight));

    assign new_entry = {n_right, n_straight, n_left};
    assign min_ls    = min2(n_left, n_straight);
    assign new_min   = min2(min_ls, n_right);

endmodule

// ----- sv/gmp_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gmp_checker
// Port-level checks for the constrained minimum path sum block.
// ============================================================================
module gmp_checker import gmp_pkg::*; #(
    parameter int COST_BITS = DEF_COST_BITS,
    parameter int SUM_BITS  = DEF_SUM_BITS
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [COST_BITS-1:0]  s_cell_cost,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [SUM_BITS-1:0]   m_min_cost,
    input logic                  m_no_path,
    input logic                  cfg_valid,
    input logic                  cfg_ready
);

    // a stalled cell transaction holds
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_cell_cost))
        else $error("cell changed while stalled");

    // a stalled result transaction holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_min_cost) && $stable(m_no_path))
        else $error("result changed while stalled");

    // no-path flag agrees with the saturated cost code
    a_no_path_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_no_path == (&m_min_cost)))
        else $error("no_path flag does not match min_cost");

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // register writes are never back-pressured
    a_cfg_open: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("register write stalled");

endmodule

bind grid_min_path_no_repeat_dir gmp_checker #(
    .COST_BITS (COST_BITS),
    .SUM_BITS  (SUM_BITS)
) u_gmp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_cell_cost (s_cell_cost),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_min_cost  (m_min_cost),
    .m_no_path   (m_no_path),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
);

// ----- tb/tb_grid_min_path_no_repeat_dir.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_grid_min_path_no_repeat_dir
// Self-checking testbench for the constrained minimum path sum block.
// ============================================================================
// Cell costs are streamed into the block under random source gaps and sink
// stalls. A scoreboard class tracks the row sums, the column and row position
// and the running best of the bottom row. It works out the path cost that
// each completed grid should give, and checks every result transaction
// against it. Grid sizes are changed between phases, including the
// out-of-range, unused-index and mid-grid restart cases.
module tb_grid_min_path_no_repeat_dir;
    import gmp_pkg::*;

    localparam int MAX_COLS = DEF_MAX_COLS;
    localparam int MAX_ROWS = DEF_MAX_ROWS;
    localparam int COST_W   = DEF_COST_BITS;
    localparam int SUM_W    = DEF_SUM_BITS;

    localparam int RANDOM_CELLS  = 1750;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    typedef logic [SUM_W-1:0] sum_t;
    localparam sum_t INF_SUM = '1;

    typedef struct {
        sum_t cost;
        logic no_path;
    } path_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: row-sum tracker plus result checker
    // ------------------------------------------------------------------------
    class path_cost_board;
        sum_t           not_left[MAX_COLS];
        sum_t           not_straight[MAX_COLS];
        sum_t           not_right[MAX_COLS];
        sum_t           win_lo[3];
        sum_t           win_hi[3];
        int unsigned    col;
        int unsigned    row;
        sum_t           best;
        logic [NUM_COLS_W-1:0] cols_reg;
        logic [NUM_ROWS_W-1:0] rows_reg;
        path_result_t   awaited_costs[$];
        int unsigned    errors;
        int unsigned    compared;

        function new();
            cols_reg = NUM_COLS_RST;
            rows_reg = NUM_ROWS_RST;
            foreach (not_left[k]) begin
                not_left[k]     = '0;
                not_straight[k] = '0;
                not_right[k]    = '0;
            end
            errors   = 0;
            compared = 0;
            restart_grid();
        endfunction

        function void restart_grid();
            win_lo = '{INF_SUM, INF_SUM, INF_SUM};
            win_hi = '{INF_SUM, INF_SUM, INF_SUM};
            col    = 0;
            row    = 0;
            best   = INF_SUM;
        endfunction

        function sum_t sat_add(sum_t a, sum_t b);
            logic [SUM_W:0] s;
            if (a == INF_SUM || b == INF_SUM) return INF_SUM;
            s = {1'b0, a} + {1'b0, b};
            return (s >= {1'b0, INF_SUM}) ? INF_SUM : s[SUM_W-1:0];
        endfunction

        function sum_t min_sum(sum_t a, sum_t b);
            return (a < b) ? a : b;
        endfunction

        // sizes as the block uses them: clamped into range
        function int unsigned span_cols();
            if (cols_reg == 0) return 1;
            if (cols_reg > MAX_COLS) return MAX_COLS;
            return cols_reg;
        endfunction

        function int unsigned span_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAX_ROWS) return MAX_ROWS;
            return rows_reg;
        endfunction

        function int unsigned grid_cells();
            return span_cols() * span_rows();
        endfunction

        function int unsigned outstanding();
            return awaited_costs.size();
        endfunction

        // any write to a real register restarts the grid
        function void note_reg_write(logic [CFG_IDX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            if (idx == REG_NUM_COLS)
                cols_reg = data[NUM_COLS_W-1:0];
            else if (idx == REG_NUM_ROWS)
                rows_reg = data[NUM_ROWS_W-1:0];
            else
                return;
            restart_grid();
        endfunction

        // one accepted cell: update the row store, maybe finish a grid
        function void take_cell(logic [COST_W-1:0] cost);
            int unsigned  n_cols;
            int unsigned  n_rows;
            int unsigned  j;
            sum_t         c;
            sum_t         l_right;
            sum_t         m_straight;
            sum_t         r_left;
            sum_t         n_l;
            sum_t         n_s;
            sum_t         n_r;
            path_result_t res;

            n_cols = span_cols();
            n_rows = span_rows();
            c      = sum_t'(cost);
            j      = (col >= n_cols) ? n_cols - 1 : col;

            // slide the window of previous-row triples one column on
            if (j == 0)
                win_lo = '{INF_SUM, INF_SUM, INF_SUM};
            else
                win_lo = win_hi;
            win_hi = '{not_left[j], not_straight[j], not_right[j]};

            // row above the grid is all zero; beside the grid is infinity
            if (row == 0) begin
                l_right    = '0;
                m_straight = '0;
                r_left     = '0;
            end else begin
                l_right    = win_lo[2];
                m_straight = win_hi[1];
                r_left     = (j + 1 < n_cols) ? not_left[j + 1] : INF_SUM;
            end

            n_l = sat_add(c, min_sum(m_straight, l_right));
            n_s = sat_add(c, min_sum(l_right, r_left));
            n_r = sat_add(c, min_sum(r_left, m_straight));
            not_left[j]     = n_l;
            not_straight[j] = n_s;
            not_right[j]    = n_r;

            if (row + 1 >= n_rows)
                best = min_sum(best, min_sum(n_l, min_sum(n_s, n_r)));

            if (j + 1 < n_cols) begin
                col = j + 1;
                return;
            end
            col = 0;
            if (row + 1 < n_rows) begin
                row = row + 1;
                return;
            end

            // grid complete: one result
            res.cost    = best;
            res.no_path = (best == INF_SUM);
            awaited_costs.push_back(res);
            restart_grid();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $time, what);
            errors++;
        endtask

        task check_cost(sum_t got_cost, logic got_no_path);
            path_result_t want;
            if (awaited_costs.size() == 0) begin
                report_mismatch($sformatf("result with none pending: cost=%0d no_path=%0b",
                                          got_cost, got_no_path));
                return;
            end
            want = awaited_costs.pop_front();
            compared++;
            if (got_cost !== want.cost)
                report_mismatch($sformatf("min_cost %0d, wanted %0d", got_cost, want.cost));
            if (got_no_path !== want.no_path)
                report_mismatch($sformatf("no_path %0b, wanted %0b", got_no_path,
                                          want.no_path));
        endtask

        task close_out();
            if (awaited_costs.size() != 0)
                report_mismatch($sformatf("%0d path costs never arrived",
                                          awaited_costs.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [COST_W-1:0]     s_cell_cost = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [SUM_W-1:0]      m_min_cost;
    logic                  m_no_path;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    path_cost_board board;
    logic           steady      = 1'b0;
    int unsigned    cells_total = 0;
    int unsigned    cells_rand  = 0;
    int unsigned    settings    = 0;

    grid_min_path_no_repeat_dir i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cell_cost (s_cell_cost),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_min_cost  (m_min_cost),
        .m_no_path   (m_no_path),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result sink: stalls about 30% of cycles outside the steady stretch
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 30);
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_cost(m_min_cost, m_no_path);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // one cell transaction; valid stays high afterwards unless a gap follows
    task send_cell(input logic [COST_W-1:0] cost);
        int unsigned gap;
        gap = (!steady && $urandom_range(0, 99) < 30) ? $urandom_range(1, 2) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_cell_cost <= cost;
        do @(posedge aclk); while (!s_ready);
        board.take_cell(cost);
        cells_total++;
    endtask

    task lower_cells();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // stop sending, let every pending result drain, then let the block settle
    task quiesce();
        lower_cells();
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.note_reg_write(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // both size registers, in random order
    task set_grid(input int unsigned cols_v, input int unsigned rows_v);
        quiesce();
        if ($urandom_range(0, 1)) begin
            write_reg(REG_NUM_COLS, CFG_DATA_W'(cols_v));
            write_reg(REG_NUM_ROWS, CFG_DATA_W'(rows_v));
        end else begin
            write_reg(REG_NUM_ROWS, CFG_DATA_W'(rows_v));
            write_reg(REG_NUM_COLS, CFG_DATA_W'(cols_v));
        end
        settings++;
    endtask

    function logic [COST_W-1:0] pick_cost();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return COST_W'($urandom_range(0, (1 << COST_W) - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase;
        int unsigned pick;
        int unsigned cols_v;
        int unsigned rows_v;
        int unsigned n_grids;
        int unsigned n_cells;
        int unsigned waited;

        board = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed ---
        // single cell grid, both cost extremes
        set_grid(1, 1);
        send_cell('1);
        send_cell('0);
        // single column: nothing beside it, so no path past the second row
        set_grid(1, 3);
        repeat (3) send_cell('1);
        // unused index written mid-grid must not restart it
        set_grid(3, 2);
        send_cell(8'd5);
        send_cell('1);
        quiesce();
        write_reg(REG_UNUSED_A, '1);
        repeat (4) send_cell(pick_cost());
        // real register written mid-grid restarts it
        send_cell('0);
        send_cell('1);
        quiesce();
        write_reg(REG_NUM_ROWS, CFG_DATA_W'(2));
        send_cell(8'd3);
        send_cell('1);
        send_cell(8'd7);
        send_cell('0);
        send_cell('1);
        send_cell(8'd1);
        // zero sizes clamp to one
        quiesce();
        write_reg(REG_UNUSED_B, '0);
        set_grid(0, 0);
        send_cell(8'd42);

        // --- random phases ---
        phase = 0;
        while (cells_rand < RANDOM_CELLS) begin
            if (phase == 0) begin
                // the reset-default size again, rewritten
                set_grid(NUM_COLS_RST, NUM_ROWS_RST);
            end else begin
                pick = $urandom_range(0, 99);
                if (phase == 3) begin
                    // tallest grid, register value possibly above the clamp
                    cols_v = 1;
                    rows_v = $urandom_range(MAX_ROWS, (1 << NUM_ROWS_W) - 1);
                end else if (pick < 70) begin
                    cols_v = $urandom_range(1, 8);
                    rows_v = $urandom_range(1, 8);
                end else if (pick < 80) begin
                    cols_v = $urandom_range(9, 20);
                    rows_v = $urandom_range(1, 4);
                end else if (pick < 86) begin
                    // widest grid, possibly above the clamp
                    cols_v = $urandom_range(MAX_COLS, (1 << NUM_COLS_W) - 1);
                    rows_v = $urandom_range(1, 3);
                end else if (pick < 93) begin
                    cols_v = $urandom_range(0, 2);
                    rows_v = $urandom_range(1, 40);
                end else begin
                    cols_v = $urandom_range(1, 8);
                    rows_v = 0;
                end
                set_grid(cols_v, rows_v);
                if ($urandom_range(0, 99) < 15)
                    write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
                              CFG_DATA_W'($urandom));
            end

            n_grids = (board.grid_cells() > 200) ? 1 : $urandom_range(1, 4);
            for (int g = 0; g < n_grids; g++) begin
                n_cells = board.grid_cells();
                // sometimes leave the last grid unfinished for the next write
                if (g == n_grids - 1 && n_cells > 1 && $urandom_range(0, 99) < 10)
                    n_cells = $urandom_range(1, n_cells - 1);
                for (int c = 0; c < n_cells; c++) begin
                    send_cell(pick_cost());
                    cells_rand++;
                    steady = (cells_rand >= 700 && cells_rand < 1000);
                end
                // sometimes hold the source until the grid's cost is back
                if ($urandom_range(0, 99) < 10)
                    quiesce();
            end
            phase++;
        end

        // --- drain ---
        lower_cells();
        waited = 0;
        while (board.outstanding() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        board.close_out();

        $display("Drove %0d cells over %0d grid size settings (clamped, unused-index",
                 cells_total, settings);
        $display("and mid-grid restarts included); %0d path costs compared.",
                 board.compared);
        if (board.errors == 0) begin
            $display("tb_grid_min_path_no_repeat_dir: clean");
        end else begin
            $display("tb_grid_min_path_no_repeat_dir: errors");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Run limit reached");
        $display("tb_grid_min_path_no_repeat_dir: errors");
        $finish;
    end

endmodule
